>>> src/i2p_pkg.sv
// Shared types, character codes and operator helpers for the infix-to-postfix
// converter. No dependencies; every other file of the block but i2p_ifs imports it.

package i2p_pkg;

  localparam int STACK_DEPTH_DEF = 32;   // default operator stack depth
  localparam int Q_DEPTH         = 2;    // command queue between front and back

  // ASCII characters the converter reacts to
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LP    = 8'h28;
  localparam logic [7:0] CH_RP    = 8'h29;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_NONE  = 8'h00;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_OVF    = 2'd1;
  localparam logic [1:0] ST_UNM_RP = 2'd2;
  localparam logic [1:0] ST_UNM_LP = 2'd3;

  // stack entry codes
  typedef enum logic [2:0] {
    OP_LP  = 3'd0,
    OP_ADD = 3'd1,
    OP_SUB = 3'd2,
    OP_MUL = 3'd3,
    OP_DIV = 3'd4,
    OP_POW = 3'd5
  } op_code_t;

  // character class decided by the front end
  typedef enum logic [2:0] {
    K_OPND  = 3'd0,
    K_SPACE = 3'd1,
    K_OPER  = 3'd2,
    K_LP    = 3'd3,
    K_RP    = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    op_code_t   code;
    logic [7:0] ch;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic [1:0] op_prec(input op_code_t op);
    logic [1:0] p;
    unique case (op)
      OP_ADD, OP_SUB: p = 2'd1;
      OP_MUL, OP_DIV: p = 2'd2;
      OP_POW:         p = 2'd3;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] op_char(input op_code_t op);
    logic [7:0] c;
    unique case (op)
      OP_ADD:  c = CH_ADD;
      OP_SUB:  c = CH_SUB;
      OP_MUL:  c = CH_MUL;
      OP_DIV:  c = CH_DIV;
      OP_POW:  c = CH_POW;
      default: c = CH_LP;
    endcase
    return c;
  endfunction

endpackage

>>> src/i2p_ifs.sv
// Valid/ready channel interfaces for the converter's input and result words.
// Standalone; no package dependency.

interface i2p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, in_char, in_last, input ready);
  modport sink   (input valid, in_char, in_last, output ready);
endinterface

interface i2p_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_valid;
  logic       run_last;
  logic       expr_done;
  logic [1:0] status;

  modport source (output valid, out_char, out_valid, run_last, expr_done, status,
                  input ready);
  modport sink   (input valid, out_char, out_valid, run_last, expr_done, status,
                  output ready);
endinterface

>>> src/infix_to_postfix_converter.sv
// Top level of the shunting-yard infix-to-postfix converter.
// Depends on i2p_pkg, i2p_ifs, i2p_front, i2p_queue and i2p_back.

// Converts an infix expression, one character per input word, into postfix
// form, one character per result word. Operands pass straight through;
// + - * / ^ are reordered on an operator stack of STACK_DEPTH entries ('^'
// binds tightest and is right-associative), parentheses group, spaces are
// skipped. The word marked in_last closes the expression: the stack is
// flushed, and the final result word carries expr_done and the final status
// (0 ok, 1 stack overflow, 2 unmatched ')', 3 unmatched '('); if that input
// yields no character, a status-only word (out_valid 0, out_char 0) is sent.
// After an error, remaining characters of the expression give no words.
// run_last marks the last word caused by each input.
// The front end queues up to two words ahead, so input is taken while the
// back end works. The back end handles one word at a time: a space is
// skipped, '(' is pushed, an operand is held and then sent, an operator
// pops the entries that bind at least as tightly (for '^', only tighter
// ones) and is then pushed, and ')' pops operators until it drops its '('
// or finds the stack empty. The word marked last then flushes each stack
// entry, finds the stack empty and sends the closing word. The back-end
// sequencer pops one stack entry per cycle while the output is not stalled,
// through a stack memory with one write port and one registered read port.
// Output stalls hold the back end; no clearing pass is needed at reset.

module infix_to_postfix_converter import i2p_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF   // 2..63
) (
  input logic       clk,
  input logic       rst_n,
  i2p_in_if.sink    in_ch,
  i2p_out_if.source out_ch
);

  q_stat_t q_stat;
  cmd_t    q_wdata, q_rdata;
  logic    q_push, q_pop;

  // classify characters into commands
  i2p_front u_front (
    .in_ch   (in_ch),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  // decouples the input handshake from stack popping
  i2p_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // stack engine and result register
  i2p_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_data (q_rdata),
    .q_stat (q_stat),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

  // an accepted word is always waiting in the queue next cycle
  a_queue_holds_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !q_stat.empty)
    else $error("accepted word missing from command queue");

  // a status-only word only ever closes an expression
  a_status_word_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.out_valid) |->
      (out_ch.expr_done && out_ch.run_last && out_ch.out_char == CH_NONE))
    else $error("status-only word outside expression end");

  // end of expression is also end of that input's run
  a_done_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.expr_done) |-> out_ch.run_last)
    else $error("expr_done without run_last");

endmodule

>>> src/i2p_queue.sv
// Small command FIFO between the front end and the stack engine.
// Depends on i2p_pkg (cmd_t, q_stat_t, Q_DEPTH).

module i2p_queue import i2p_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    wdata,
  input  logic    pop,
  output cmd_t    rdata,
  output q_stat_t stat
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int NW = $clog2(Q_DEPTH + 1);

  cmd_t          entry_r [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] fill_r, fill_nxt;
  logic          do_push, do_pop;

  assign stat.empty = (fill_r == '0);
  assign stat.full  = (fill_r == NW'(Q_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> src/i2p_front.sv
// Front end: takes input words and classifies each character into a command.
// Depends on i2p_pkg and the i2p_in_if interface.

module i2p_front import i2p_pkg::*; (
  i2p_in_if.sink  in_ch,
  input  q_stat_t q_stat,
  output logic    q_push,
  output cmd_t    q_wdata
);

  assign in_ch.ready = !q_stat.full;
  assign q_push      = in_ch.valid && !q_stat.full;

  always_comb begin
    q_wdata.ch   = in_ch.in_char;
    q_wdata.last = in_ch.in_last;
    q_wdata.code = OP_LP;
    q_wdata.kind = K_OPND;
    unique case (in_ch.in_char)
      CH_SPACE: q_wdata.kind = K_SPACE;
      CH_LP:    q_wdata.kind = K_LP;
      CH_RP:    q_wdata.kind = K_RP;
      CH_ADD: begin
        q_wdata.kind = K_OPER;
        q_wdata.code = OP_ADD;
      end
      CH_SUB: begin
        q_wdata.kind = K_OPER;
        q_wdata.code = OP_SUB;
      end
      CH_MUL: begin
        q_wdata.kind = K_OPER;
        q_wdata.code = OP_MUL;
      end
      CH_DIV: begin
        q_wdata.kind = K_OPER;
        q_wdata.code = OP_DIV;
      end
      CH_POW: begin
        q_wdata.kind = K_OPER;
        q_wdata.code = OP_POW;
      end
      default: q_wdata.kind = K_OPND;
    endcase
  end

endmodule

>>> src/i2p_back.sv
// Back end: operator stack engine and output register for result words.
// Depends on i2p_pkg and the i2p_out_if interface.

module i2p_back import i2p_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cmd_t    q_data,
  input  q_stat_t q_stat,
  output logic    q_pop,
  i2p_out_if.source out_ch
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [4:0] {
    S_FETCH = 5'b00001,
    S_POPOP = 5'b00010,
    S_POPRP = 5'b00100,
    S_FLUSH = 5'b01000,
    S_FINAL = 5'b10000
  } state_t;

  op_code_t stack_mem [STACK_DEPTH];

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    err_r, err_nxt;
  op_code_t      top_r, top_nxt;
  op_code_t      below_r;            // registered read of the entry under the top
  cmd_t          cmd_r, cmd_nxt;
  logic          hold_v_r, hold_v_nxt;
  logic [7:0]    hold_ch_r, hold_ch_nxt;
  logic [1:0]    hold_st_r, hold_st_nxt;

  logic          ov_r, ov_nxt;
  logic [7:0]    o_char_r, o_char_nxt;
  logic          o_cv_r, o_cv_nxt;
  logic          o_rl_r, o_rl_nxt;
  logic          o_ed_r, o_ed_nxt;
  logic [1:0]    o_st_r, o_st_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_wa, rd_addr;
  op_code_t      mem_wd;

  logic          out_space, emit_ok, stack_full, can_pop;
  logic [1:0]    top_prec, cmd_prec;

  assign out_space  = !ov_r || out_ch.ready;
  assign emit_ok    = !hold_v_r || out_space;
  assign stack_full = (cnt_r >= CW'(STACK_DEPTH));
  assign top_prec   = op_prec(top_r);
  assign cmd_prec   = op_prec(cmd_r.code);
  // '^' is right-associative: equal precedence stays on the stack
  assign can_pop    = (cnt_r != '0) && (top_r != OP_LP) &&
                      ((cmd_r.code == OP_POW) ? (top_prec > cmd_prec)
                                              : (top_prec >= cmd_prec));

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    err_nxt     = err_r;
    top_nxt     = top_r;
    cmd_nxt     = cmd_r;
    hold_v_nxt  = hold_v_r;
    hold_ch_nxt = hold_ch_r;
    hold_st_nxt = hold_st_r;
    ov_nxt      = ov_r && !out_ch.ready;
    o_char_nxt  = o_char_r;
    o_cv_nxt    = o_cv_r;
    o_rl_nxt    = o_rl_r;
    o_ed_nxt    = o_ed_r;
    o_st_nxt    = o_st_r;
    mem_we      = 1'b0;
    mem_wa      = cnt_r[AW-1:0];
    mem_wd      = OP_LP;
    q_pop       = 1'b0;

    unique case (state_r)
      S_FETCH: begin
        if (!q_stat.empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_data;
          if (err_r != ST_OK) begin
            // rest of a failed expression is dropped; the last word closes it
            state_nxt = q_data.last ? S_FINAL : S_FETCH;
          end else begin
            unique case (q_data.kind)
              K_SPACE: state_nxt = q_data.last ? S_FLUSH : S_FETCH;
              K_OPND: begin
                hold_v_nxt  = 1'b1;
                hold_ch_nxt = q_data.ch;
                hold_st_nxt = err_r;
                state_nxt   = q_data.last ? S_FLUSH : S_FINAL;
              end
              K_OPER: state_nxt = S_POPOP;
              K_RP:   state_nxt = S_POPRP;
              K_LP: begin
                if (stack_full) begin
                  err_nxt = ST_OVF;
                end else begin
                  mem_we  = 1'b1;
                  mem_wd  = OP_LP;
                  cnt_nxt = cnt_r + 1'b1;
                  top_nxt = OP_LP;
                end
                if (q_data.last) begin
                  state_nxt = (err_nxt == ST_OK) ? S_FLUSH : S_FINAL;
                end else begin
                  state_nxt = S_FETCH;
                end
              end
              default: state_nxt = S_FETCH;
            endcase
          end
        end
      end

      S_POPOP: begin
        if (can_pop) begin
          if (emit_ok) begin
            if (hold_v_r) begin
              ov_nxt     = 1'b1;
              o_char_nxt = hold_ch_r;
              o_cv_nxt   = 1'b1;
              o_rl_nxt   = 1'b0;
              o_ed_nxt   = 1'b0;
              o_st_nxt   = hold_st_r;
            end
            hold_v_nxt  = 1'b1;
            hold_ch_nxt = op_char(top_r);
            hold_st_nxt = err_r;
            cnt_nxt     = cnt_r - 1'b1;
            top_nxt     = below_r;
          end
        end else begin
          if (stack_full) begin
            err_nxt = ST_OVF;
          end else begin
            mem_we  = 1'b1;
            mem_wd  = cmd_r.code;
            cnt_nxt = cnt_r + 1'b1;
            top_nxt = cmd_r.code;
          end
          state_nxt = (cmd_r.last && err_nxt == ST_OK) ? S_FLUSH : S_FINAL;
        end
      end

      S_POPRP: begin
        if (cnt_r == '0) begin
          err_nxt   = ST_UNM_RP;
          state_nxt = S_FINAL;
        end else if (top_r == OP_LP) begin
          cnt_nxt   = cnt_r - 1'b1;
          top_nxt   = below_r;
          state_nxt = cmd_r.last ? S_FLUSH : S_FINAL;
        end else if (emit_ok) begin
          if (hold_v_r) begin
            ov_nxt     = 1'b1;
            o_char_nxt = hold_ch_r;
            o_cv_nxt   = 1'b1;
            o_rl_nxt   = 1'b0;
            o_ed_nxt   = 1'b0;
            o_st_nxt   = hold_st_r;
          end
          hold_v_nxt  = 1'b1;
          hold_ch_nxt = op_char(top_r);
          hold_st_nxt = err_r;
          cnt_nxt     = cnt_r - 1'b1;
          top_nxt     = below_r;
        end
      end

      S_FLUSH: begin
        if (cnt_r == '0) begin
          state_nxt = S_FINAL;
        end else if (top_r == OP_LP) begin
          // stray '(' is dropped; flushing goes on
          cnt_nxt = cnt_r - 1'b1;
          top_nxt = below_r;
          if (err_r == ST_OK) begin
            err_nxt = ST_UNM_LP;
          end
        end else if (emit_ok) begin
          if (hold_v_r) begin
            ov_nxt     = 1'b1;
            o_char_nxt = hold_ch_r;
            o_cv_nxt   = 1'b1;
            o_rl_nxt   = 1'b0;
            o_ed_nxt   = 1'b0;
            o_st_nxt   = hold_st_r;
          end
          hold_v_nxt  = 1'b1;
          hold_ch_nxt = op_char(top_r);
          hold_st_nxt = err_r;
          cnt_nxt     = cnt_r - 1'b1;
          top_nxt     = below_r;
        end
      end

      S_FINAL: begin
        // release the held word as the last of this input
        if (hold_v_r) begin
          if (out_space) begin
            ov_nxt     = 1'b1;
            o_char_nxt = hold_ch_r;
            o_cv_nxt   = 1'b1;
            o_rl_nxt   = 1'b1;
            o_ed_nxt   = cmd_r.last;
            o_st_nxt   = cmd_r.last ? err_r : hold_st_r;
            hold_v_nxt = 1'b0;
            state_nxt  = S_FETCH;
            if (cmd_r.last) begin
              cnt_nxt = '0;
              err_nxt = ST_OK;
            end
          end
        end else if (cmd_r.last) begin
          if (out_space) begin
            ov_nxt     = 1'b1;
            o_char_nxt = CH_NONE;
            o_cv_nxt   = 1'b0;
            o_rl_nxt   = 1'b1;
            o_ed_nxt   = 1'b1;
            o_st_nxt   = err_r;
            cnt_nxt    = '0;
            err_nxt    = ST_OK;
            state_nxt  = S_FETCH;
          end
        end else begin
          state_nxt = S_FETCH;
        end
      end

      default: state_nxt = S_FETCH;
    endcase
  end

  // read the entry under the next top, so a pop can use it next cycle
  assign rd_addr = (cnt_nxt >= CW'(2)) ? AW'(cnt_nxt - CW'(2)) : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_wa] <= mem_wd;
    end
    below_r <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_FETCH;
      cnt_r    <= '0;
      err_r    <= ST_OK;
      hold_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      err_r    <= err_nxt;
      hold_v_r <= hold_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r     <= top_nxt;
    cmd_r     <= cmd_nxt;
    hold_ch_r <= hold_ch_nxt;
    hold_st_r <= hold_st_nxt;
    o_char_r  <= o_char_nxt;
    o_cv_r    <= o_cv_nxt;
    o_rl_r    <= o_rl_nxt;
    o_ed_r    <= o_ed_nxt;
    o_st_r    <= o_st_nxt;
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.out_char  = o_char_r;
  assign out_ch.out_valid = o_cv_r;
  assign out_ch.run_last  = o_rl_r;
  assign out_ch.expr_done = o_ed_r;
  assign out_ch.status    = o_st_r;

endmodule

>>> tb/sv/infix_to_postfix_converter_checker.sv
// Checker for the infix-to-postfix converter: predicts the postfix words of every
// accepted input word and compares them with the words the block sends.
// Depends on i2p_pkg and the channel interfaces in i2p_ifs.

module postfix_checker import i2p_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  i2p_in_if    in_mon,
  i2p_out_if   out_mon,
  output int   fail_count,
  output int   words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       chr_vld;
    logic       run_end;
    logic       done;
    logic [1:0] st;
  } postfix_word_t;

  // shadow of the operator stack
  op_code_t      shadow_stk [64];
  int unsigned   shadow_depth;
  logic [1:0]    shadow_err;
  postfix_word_t postfix_q [$];

  function automatic logic [1:0] rank(input op_code_t op);
    case (op)
      OP_POW:         return 2'd3;
      OP_MUL, OP_DIV: return 2'd2;
      OP_ADD, OP_SUB: return 2'd1;
      default:        return 2'd0;
    endcase
  endfunction

  function automatic logic [7:0] glyph(input op_code_t op);
    case (op)
      OP_ADD:  return CH_ADD;
      OP_SUB:  return CH_SUB;
      OP_MUL:  return CH_MUL;
      OP_DIV:  return CH_DIV;
      OP_POW:  return CH_POW;
      default: return CH_LP;
    endcase
  endfunction

  function automatic bit arith_code(input logic [7:0] c, output op_code_t code);
    code = OP_LP;
    case (c)
      CH_ADD: code = OP_ADD;
      CH_SUB: code = OP_SUB;
      CH_MUL: code = OP_MUL;
      CH_DIV: code = OP_DIV;
      CH_POW: code = OP_POW;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // status field carries the error code at the moment the word is made
  function automatic postfix_word_t make_word(input logic [7:0] c, input logic v);
    postfix_word_t w;
    w.ch      = c;
    w.chr_vld = v;
    w.run_end = 1'b0;
    w.done    = 1'b0;
    w.st      = shadow_err;
    return w;
  endfunction

  function automatic string word_text(input postfix_word_t w);
    return $sformatf("ch=%h vld=%b run_last=%b done=%b st=%0d",
                     w.ch, w.chr_vld, w.run_end, w.done, w.st);
  endfunction

  task automatic push_code(input op_code_t code);
    if (shadow_depth >= STACK_DEPTH) begin
      shadow_err = ST_OVF;
    end else begin
      shadow_stk[shadow_depth] = code;
      shadow_depth++;
    end
  endtask

  task automatic predict_postfix(input logic [7:0] c, input logic lst);
    postfix_word_t run [$];
    op_code_t      code;
    op_code_t      top;
    bit            is_op;
    bit            stop;
    logic [1:0]    p;
    run = {};
    if (shadow_err == ST_OK) begin
      is_op = arith_code(c, code);
      if (c == CH_SPACE) begin
        // skipped
      end else if (is_op) begin
        p    = rank(code);
        stop = 1'b0;
        while (shadow_depth > 0 && !stop) begin
          top = shadow_stk[shadow_depth - 1];
          if (top == OP_LP) begin
            stop = 1'b1;
          end else if ((code == OP_POW) ? (rank(top) > p) : (rank(top) >= p)) begin
            shadow_depth--;
            run.push_back(make_word(glyph(top), 1'b1));
          end else begin
            stop = 1'b1;
          end
        end
        push_code(code);
      end else if (c == CH_LP) begin
        push_code(OP_LP);
      end else if (c == CH_RP) begin
        stop = 1'b0;
        while (!stop) begin
          if (shadow_depth == 0) begin
            shadow_err = ST_UNM_RP;
            stop       = 1'b1;
          end else begin
            shadow_depth--;
            top = shadow_stk[shadow_depth];
            if (top == OP_LP) stop = 1'b1;
            else run.push_back(make_word(glyph(top), 1'b1));
          end
        end
      end else begin
        run.push_back(make_word(c, 1'b1));
      end
    end
    if (lst) begin
      if (shadow_err == ST_OK) begin
        while (shadow_depth > 0) begin
          shadow_depth--;
          top = shadow_stk[shadow_depth];
          if (top == OP_LP) begin
            if (shadow_err == ST_OK) shadow_err = ST_UNM_LP;
          end else begin
            run.push_back(make_word(glyph(top), 1'b1));
          end
        end
      end
      if (run.size() == 0) run.push_back(make_word(CH_NONE, 1'b0));
      run[run.size() - 1].done = 1'b1;
      run[run.size() - 1].st   = shadow_err;
      shadow_depth = 0;
      shadow_err   = ST_OK;
    end
    if (run.size() > 0) run[run.size() - 1].run_end = 1'b1;
    foreach (run[i]) postfix_q.push_back(run[i]);
  endtask

  task automatic compare_postfix();
    postfix_word_t got;
    postfix_word_t want;
    got.ch      = out_mon.out_char;
    got.chr_vld = out_mon.out_valid;
    got.run_end = out_mon.run_last;
    got.done    = out_mon.expr_done;
    got.st      = out_mon.status;
    if (postfix_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: unexpected word %s", $realtime, word_text(got));
    end else begin
      want = postfix_q.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: word mismatch exp %s got %s", $realtime,
                   word_text(want), word_text(got));
      end
    end
  endtask

  // output first: a word leaving at this edge never stems from the input taken at it
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_depth  = 0;
      shadow_err    = ST_OK;
      postfix_q.delete();
      fail_count    = 0;
      words_pending = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) compare_postfix();
      if (in_mon.valid && in_mon.ready) predict_postfix(in_mon.in_char, in_mon.in_last);
      words_pending = postfix_q.size();
    end
  end

endmodule

>>> tb/sv/infix_to_postfix_converter_tb.sv
// Top of the infix-to-postfix converter testbench: clock, reset, expression
// stimulus, result-side backpressure and the verdict.
// Depends on i2p_pkg, i2p_ifs, the converter RTL and postfix_checker.

module infix_to_postfix_converter_tb import i2p_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS  = 370;     // random input words to send
  localparam int LONG_HOLD   = 400;     // cycles of the one long output stall
  localparam int DRAIN_LIMIT = 200000;  // cycles allowed for results to drain
  localparam int TAIL_CYCLES = 40;      // > a full 32-entry flush

  logic clk;
  logic rst_n;

  i2p_in_if  in_ch ();
  i2p_out_if out_ch ();

  int fail_count;
  int words_pending;

  // knobs shared between the sender and the receiver processes
  int src_idle_pct;
  int snk_stall_pct;
  bit hold_go;
  bit hold_done;

  logic [7:0] expr_buf [$];   // characters of the expression being built
  int         rand_items;
  int         phase;
  int         pick;
  int         k;
  int         drain_cycles;

  infix_to_postfix_converter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  postfix_checker #(.STACK_DEPTH(STACK_DEPTH_DEF)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop; far above the slowest legal run (every word stalled, long hold).
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: ready changes at the falling edge only. One long hold-off is
  // done on request, counted here, so the front queue fills and in_ch.ready
  // drops while the sender keeps offering.
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    hold_done    = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender helpers. Called at a falling edge, return at a falling edge, so
  // valid gets one assignment per step and stays high across back-to-back words.
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [7:0] c, input logic lst);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_char <= c;
    in_ch.in_last <= lst;
    // accepted at the first rising edge where ready is seen high
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // sends the buffer, marking its final character last
  task automatic send_expr();
    foreach (expr_buf[i]) send_word(expr_buf[i], i == expr_buf.size() - 1);
    expr_buf.delete();
  endtask

  task automatic load_text(input string s);
    for (int i = 0; i < s.len(); i++) expr_buf.push_back(s[i]);
  endtask

  // any byte the block treats as an operand (all bits toggle over the run)
  function automatic logic [7:0] rand_operand();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_SPACE || c == CH_LP || c == CH_RP || c == CH_ADD ||
           c == CH_SUB || c == CH_MUL || c == CH_DIV || c == CH_POW);
    return c;
  endfunction

  function automatic logic [7:0] rand_arith();
    case ($urandom_range(0, 4))
      0:       return CH_ADD;
      1:       return CH_SUB;
      2:       return CH_MUL;
      3:       return CH_DIV;
      default: return CH_POW;
    endcase
  endfunction

  // term := operand | '(' expr ')', with the odd leading space
  task automatic gen_term(input int depth);
    if ($urandom_range(0, 99) < 8) expr_buf.push_back(CH_SPACE);
    if (depth > 0 && $urandom_range(0, 99) < 30) begin
      expr_buf.push_back(CH_LP);
      gen_expr(depth - 1);
      expr_buf.push_back(CH_RP);
    end else begin
      expr_buf.push_back(rand_operand());
    end
  endtask

  // expr := term (op term)*
  task automatic gen_expr(input int depth);
    int n;
    n = $urandom_range(0, 3);
    gen_term(depth);
    repeat (n) begin
      expr_buf.push_back(rand_arith());
      gen_term(depth);
    end
  endtask

  // one stray paren inserted, or one character dropped
  task automatic break_expr();
    int pos;
    pos = $urandom_range(0, expr_buf.size());
    case ($urandom_range(0, 2))
      0:       expr_buf.insert(pos, CH_LP);
      1:       expr_buf.insert(pos, CH_RP);
      default: if (pos < expr_buf.size()) expr_buf.delete(pos);
    endcase
    if (expr_buf.size() == 0) expr_buf.push_back(rand_operand());
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus and verdict
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_char = CH_NONE;
    in_ch.in_last = 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_go       = 1'b0;
    rand_items    = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: all operators, left- and right-associative popping
    load_text("A+B*C-D/E^F^G");
    send_expr();
    // matched parens
    load_text("(H)");
    send_expr();
    // unmatched ')' on an empty stack
    load_text(")");
    send_expr();
    // unmatched '(' found in the flush, closed by a space marked last
    load_text("( ");
    send_expr();
    // extreme operand codes
    expr_buf = '{8'h00, CH_MUL, 8'hFF};
    send_expr();
    // characters after an error are dropped until the expression ends
    load_text(")x");
    send_expr();

    // Random: mostly well-formed expressions, plus deep stacks (full flush,
    // overflow), broken ones and raw byte noise. Four idling phases.
    while (rand_items < RAND_ITEMS) begin
      phase = rand_items * 4 / RAND_ITEMS;
      case (phase)
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 67; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 67; end
        default: begin src_idle_pct = 24; snk_stall_pct = 24; end
      endcase
      if (phase == 0 && rand_items >= 30) hold_go = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        // right-associative chain: no pops; 32 or more '^' fill the stack, a 33rd push overflows
        k = $urandom_range(28, 34);
        repeat (k) begin
          expr_buf.push_back(rand_operand());
          expr_buf.push_back(CH_POW);
        end
        expr_buf.push_back(rand_operand());
      end else if (pick < 6) begin
        k = $urandom_range(30, 34);
        repeat (k) expr_buf.push_back(CH_LP);
        expr_buf.push_back(rand_operand());
        repeat (k) expr_buf.push_back(CH_RP);
      end else if (pick < 18) begin
        k = $urandom_range(1, 6);
        repeat (k) expr_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        gen_expr(3);
        if (pick < 33) break_expr();
        if ($urandom_range(0, 9) == 0) expr_buf.push_back(CH_SPACE);
      end
      rand_items += expr_buf.size();
      send_expr();
    end
    in_ch.valid   <= 1'b0;
    snk_stall_pct = 0;

    // drain, then a tail long enough for any late extra word to show up
    drain_cycles = 0;
    while (words_pending != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(negedge clk);
      drain_cycles++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);

    if (fail_count == 0 && words_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
